### hw/rtl/smq_pkg.sv
// ----------------------------------------------------------------------------
// smq_pkg
// shared codes and the classified transaction type of the socket queue engine
// ----------------------------------------------------------------------------
package smq_pkg;

	localparam logic [1:0] CMD_BIND = 2'd0;
	localparam logic [1:0] CMD_SEND = 2'd1;
	localparam logic [1:0] CMD_RECV = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_REFUSED = 3'd1;
	localparam logic [2:0] ST_BLOCKED = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;

	localparam int SOCK_IN_W = 6;
	localparam int PID_IN_W  = 4;
	localparam int SRC_W     = 4;
	localparam int SIZE_W    = 4;
	localparam int WORD_W    = 64;

	typedef struct packed {
		logic [1:0]           cmd;
		logic                 cmd_ok;
		logic                 sock_ok;
		logic                 pid_ok;
		logic [SOCK_IN_W-1:0] socket;
		logic [PID_IN_W-1:0]  pid;
		logic [SRC_W-1:0]     src;
		logic [SIZE_W-1:0]    size;
		logic [WORD_W-1:0]    word;
	} smq_item_t;

endpackage

### hw/rtl/socket_message_queue_engine.sv
// ----------------------------------------------------------------------------
// socket_message_queue_engine
// per-socket packet mailbox with bind, send and receive transactions
// ----------------------------------------------------------------------------
// input channel: push/full; a transaction enters when push is high and full
// is low. result channel: empty/pop; the oldest result sits on the result
// ports while empty is low and leaves when pop is high.
// each input transaction gives exactly one result, in order.
// after the accepting edge, a transaction executes out of the two-entry
// input queue against the socket table, then passes the registered packet
// memory read before empty goes low; it waits while a result is held unpopped.
// the back end takes no new transaction until the last one has finished the
// execute/read sequence of the back end and its single packet memory port.
// the input queue keeps taking transactions while a result waits; when the
// consumer holds pop low, the back end stops and full rises once both input
// queue entries are taken.
// reset clears all sockets (unbound, write pointer 1, read pointer 0), the
// queues and the result slot; the packet memory is not cleared, as a queue
// only reads slots it has written.
// ----------------------------------------------------------------------------
module socket_message_queue_engine #(
	parameter int NUM_QUEUES    = 16,
	parameter int QUEUE_DEPTH   = 32,
	parameter int NUM_PROCESSES = 16,
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    command,
	input  logic [smq_pkg::SOCK_IN_W-1:0] socket_id,
	input  logic [smq_pkg::PID_IN_W-1:0]  process_id,
	input  logic [smq_pkg::SRC_W-1:0]     sender_socket,
	input  logic [smq_pkg::SIZE_W-1:0]    payload_size,
	input  logic [smq_pkg::WORD_W-1:0]    payload_word,
	output logic                          empty,
	input  logic                          pop,
	output logic [2:0]                    status,
	output logic                          data_valid,
	output logic [smq_pkg::SRC_W-1:0]     packet_source,
	output logic [smq_pkg::SIZE_W-1:0]    packet_size,
	output logic [smq_pkg::WORD_W-1:0]    packet_payload,
	output logic                          wake_valid,
	output logic [smq_pkg::PID_IN_W-1:0]  wake_process
);
	import smq_pkg::*;

	logic      item_valid;
	logic      item_take;
	smq_item_t item;

	smq_front #(
		.NUM_QUEUES    (NUM_QUEUES),
		.NUM_PROCESSES (NUM_PROCESSES),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.command       (command),
		.socket_id     (socket_id),
		.process_id    (process_id),
		.sender_socket (sender_socket),
		.payload_size  (payload_size),
		.payload_word  (payload_word),
		.item_valid    (item_valid),
		.item          (item),
		.item_take     (item_take)
	);

	smq_back #(
		.NUM_QUEUES    (NUM_QUEUES),
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.NUM_PROCESSES (NUM_PROCESSES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item           (item),
		.item_take      (item_take),
		.empty          (empty),
		.pop            (pop),
		.status         (status),
		.data_valid     (data_valid),
		.packet_source  (packet_source),
		.packet_size    (packet_size),
		.packet_payload (packet_payload),
		.wake_valid     (wake_valid),
		.wake_process   (wake_process)
	);

endmodule

### hw/rtl/smq_front.sv
// ----------------------------------------------------------------------------
// smq_front
// accepts transactions, range checks and trims them, and holds them in a
// two-entry queue for the execution side
// ----------------------------------------------------------------------------
module smq_front #(
	parameter int NUM_QUEUES    = 16,
	parameter int NUM_PROCESSES = 16,
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     command,
	input  logic [smq_pkg::SOCK_IN_W-1:0]  socket_id,
	input  logic [smq_pkg::PID_IN_W-1:0]   process_id,
	input  logic [smq_pkg::SRC_W-1:0]      sender_socket,
	input  logic [smq_pkg::SIZE_W-1:0]     payload_size,
	input  logic [smq_pkg::WORD_W-1:0]     payload_word,
	output logic                           item_valid,
	output smq_pkg::smq_item_t             item,
	input  logic                           item_take
);
	import smq_pkg::*;

	smq_item_t   cls;
	logic [SIZE_W-1:0] sat_size;
	smq_item_t   entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push_fire;

	// classify and trim
	always_comb begin
		sat_size = (payload_size > SIZE_W'(PAYLOAD_BYTES)) ? SIZE_W'(PAYLOAD_BYTES)
			: payload_size;
		cls.cmd     = command;
		cls.cmd_ok  = (command <= CMD_RECV);
		cls.sock_ok = (32'(socket_id) < 32'(NUM_QUEUES));
		cls.pid_ok  = (32'(process_id) < 32'(NUM_PROCESSES));
		cls.socket  = socket_id;
		cls.pid     = process_id;
		cls.src     = sender_socket;
		cls.size    = sat_size;
		for (int b = 0; b < WORD_W / 8; b++) begin
			cls.word[8*b +: 8] = (b < int'(sat_size)) ? payload_word[8*b +: 8] : 8'd0;
		end
	end

	assign full       = (count_q == 2'd2);
	assign push_fire  = push && !full;
	assign item_valid = (count_q != 2'd0);
	assign item       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (item_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push_fire) - 2'(item_take);
		end
	end

endmodule

### hw/rtl/smq_back.sv
// ----------------------------------------------------------------------------
// smq_back
// executes bind, send and receive against the socket table and packet
// memory, and holds one finished result for the consumer
// ----------------------------------------------------------------------------
module smq_back #(
	parameter int NUM_QUEUES    = 16,
	parameter int QUEUE_DEPTH   = 32,
	parameter int NUM_PROCESSES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  smq_pkg::smq_item_t            item,
	output logic                          item_take,
	output logic                          empty,
	input  logic                          pop,
	output logic [2:0]                    status,
	output logic                          data_valid,
	output logic [smq_pkg::SRC_W-1:0]     packet_source,
	output logic [smq_pkg::SIZE_W-1:0]    packet_size,
	output logic [smq_pkg::WORD_W-1:0]    packet_payload,
	output logic                          wake_valid,
	output logic [smq_pkg::PID_IN_W-1:0]  wake_process
);
	import smq_pkg::*;

	localparam int SOCK_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PID_W     = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int ENTRY_W   = SIZE_W + SRC_W + WORD_W;

	typedef enum logic {S_IDLE, S_READ} state_t;

	state_t               state_q;
	logic                 owner_valid_q [NUM_QUEUES];
	logic [PID_IN_W-1:0]  owner_proc_q  [NUM_QUEUES];
	logic                 has_sock_q    [NUM_PROCESSES];
	logic [PTR_W-1:0]     wr_ptr_q      [NUM_QUEUES];
	logic [PTR_W-1:0]     rd_ptr_q      [NUM_QUEUES];
	logic                 waiting_q     [NUM_QUEUES];
	logic [ENTRY_W-1:0]   mem [MEM_DEPTH];
	logic [ENTRY_W-1:0]   rd_data_q;

	logic [2:0]           status_s1;
	logic                 dvalid_s1;
	logic                 wvalid_s1;
	logic [PID_IN_W-1:0]  wproc_s1;
	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic                 data_valid_q;
	logic [SRC_W-1:0]     source_q;
	logic [SIZE_W-1:0]    size_q;
	logic [WORD_W-1:0]    payload_q;
	logic                 wake_valid_q;
	logic [PID_IN_W-1:0]  wake_proc_q;

	logic [SOCK_W-1:0]    s;
	logic [PID_W-1:0]     p;
	logic [PTR_W-1:0]     wr;
	logic [PTR_W-1:0]     rd;
	logic [PTR_W-1:0]     wr_next;
	logic [PTR_W-1:0]     rd_next;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]    rd_addr;
	logic [2:0]           st;
	logic                 do_bind;
	logic                 do_send;
	logic                 do_recv;
	logic                 set_wait;
	logic                 wake;
	logic                 exec;
	logic                 pop_fire;

	assign s        = SOCK_W'(item.socket);
	assign p        = PID_W'(item.pid);
	assign wr       = wr_ptr_q[s];
	assign rd       = rd_ptr_q[s];
	assign wr_next  = (wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr + PTR_W'(1);
	assign rd_next  = (rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd + PTR_W'(1);
	assign wr_addr  = ADDR_W'(s) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr);
	assign rd_addr  = ADDR_W'(s) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rd_next);

	always_comb begin
		st       = ST_INVALID;
		do_bind  = 1'b0;
		do_send  = 1'b0;
		do_recv  = 1'b0;
		set_wait = 1'b0;
		wake     = 1'b0;
		if (item.sock_ok && item.cmd_ok) begin
			case (item.cmd)
				CMD_BIND: begin
					if (!item.pid_ok) begin
						st = ST_INVALID;
					end else if (owner_valid_q[s] || has_sock_q[p]) begin
						st = ST_REFUSED;
					end else begin
						st      = ST_OK;
						do_bind = 1'b1;
					end
				end
				CMD_SEND: begin
					if (!owner_valid_q[s]) begin
						st = ST_INVALID;
					end else if (wr == rd) begin
						st = ST_FULL;
					end else begin
						st      = ST_OK;
						do_send = 1'b1;
						wake    = waiting_q[s];
					end
				end
				CMD_RECV: begin
					if (!item.pid_ok || !owner_valid_q[s]) begin
						st = ST_INVALID;
					end else if (owner_proc_q[s] != item.pid) begin
						st = ST_REFUSED;
					end else if (rd_next == wr) begin
						st       = ST_BLOCKED;
						set_wait = 1'b1;
					end else begin
						st      = ST_OK;
						do_recv = 1'b1;
					end
				end
				default: begin
					st = ST_INVALID;
				end
			endcase
		end
	end

	assign pop_fire  = pop && out_valid_q;
	assign exec      = item_valid && (state_q == S_IDLE) && (!out_valid_q || pop_fire);
	assign item_take = exec;

	// socket table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				owner_valid_q[i] <= 1'b0;
				owner_proc_q[i]  <= '0;
				wr_ptr_q[i]      <= PTR_W'(1);
				rd_ptr_q[i]      <= '0;
				waiting_q[i]     <= 1'b0;
			end
			for (int i = 0; i < NUM_PROCESSES; i++) begin
				has_sock_q[i] <= 1'b0;
			end
		end else if (exec) begin
			if (do_bind) begin
				owner_valid_q[s] <= 1'b1;
				owner_proc_q[s]  <= item.pid;
				has_sock_q[p]    <= 1'b1;
				wr_ptr_q[s]      <= PTR_W'(1);
				rd_ptr_q[s]      <= '0;
				waiting_q[s]     <= 1'b0;
			end
			if (do_send) begin
				wr_ptr_q[s] <= wr_next;
				if (wake) begin
					waiting_q[s] <= 1'b0;
				end
			end
			if (do_recv) begin
				rd_ptr_q[s] <= rd_next;
			end
			if (set_wait) begin
				waiting_q[s] <= 1'b1;
			end
		end
	end

	// packet memory
	always_ff @(posedge clk) begin
		if (exec && do_send) begin
			mem[wr_addr] <= {item.size, item.src, item.word};
		end
		if (exec && do_recv) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			status_s1    <= ST_OK;
			dvalid_s1    <= 1'b0;
			wvalid_s1    <= 1'b0;
			wproc_s1     <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			data_valid_q <= 1'b0;
			source_q     <= '0;
			size_q       <= '0;
			payload_q    <= '0;
			wake_valid_q <= 1'b0;
			wake_proc_q  <= '0;
		end else begin
			if (pop_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (exec) begin
						state_q   <= S_READ;
						status_s1 <= st;
						dvalid_s1 <= do_recv;
						wvalid_s1 <= wake;
						wproc_s1  <= wake ? owner_proc_q[s] : '0;
					end
				end
				S_READ: begin
					state_q      <= S_IDLE;
					out_valid_q  <= 1'b1;
					status_q     <= status_s1;
					data_valid_q <= dvalid_s1;
					source_q     <= dvalid_s1 ? rd_data_q[WORD_W +: SRC_W] : '0;
					size_q       <= dvalid_s1 ? rd_data_q[WORD_W + SRC_W +: SIZE_W] : '0;
					payload_q    <= dvalid_s1 ? rd_data_q[WORD_W-1:0] : '0;
					wake_valid_q <= wvalid_s1;
					wake_proc_q  <= wproc_s1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign empty          = !out_valid_q;
	assign status         = status_q;
	assign data_valid     = data_valid_q;
	assign packet_source  = source_q;
	assign packet_size    = size_q;
	assign packet_payload = payload_q;
	assign wake_valid     = wake_valid_q;
	assign wake_process   = wake_proc_q;

endmodule

### hw/rtl/smq_checker.sv
// ----------------------------------------------------------------------------
// smq_checker
// port-level checks on the result channel of the socket queue engine
// ----------------------------------------------------------------------------
module smq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic [2:0]                    status,
	input logic                          data_valid,
	input logic [smq_pkg::SRC_W-1:0]     packet_source,
	input logic [smq_pkg::SIZE_W-1:0]    packet_size,
	input logic [smq_pkg::WORD_W-1:0]    packet_payload,
	input logic                          wake_valid
);
	import smq_pkg::*;

	// a waiting transaction stays until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(packet_payload)))
		else $error("result changed while stalled");

	// a returned packet always reports success
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && data_valid) |-> (status == ST_OK))
		else $error("packet returned with failing status");

	// a wake only comes from a successful send
	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && wake_valid) |-> (status == ST_OK && !data_valid))
		else $error("wake without a successful send");

	// packet fields are zero when no packet is returned
	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !data_valid) |->
			(packet_source == '0 && packet_size == '0 && packet_payload == '0))
		else $error("packet fields set without a packet");

endmodule

bind socket_message_queue_engine smq_checker u_smq_checker (.*);
